// ===== rtl/core/point_segment_distance_sq_macros.svh =====
// ---------------------------------------------------------------------------
// point_segment_distance_sq_macros : assertion helpers
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_SQ_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_SQ_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define PSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// checked at every edge, reset included
`define PSD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define PSD_ASSERT(lbl, clk, rst_n, prop)
`define PSD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/psd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psd_pkg
// Widths, constants and types shared by the point-segment distance pipeline.
// ---------------------------------------------------------------------------
package psd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LNG_W     = 32;
    localparam int LAT_W     = 31;
    localparam int D_W       = LNG_W + 1;          // coordinate differences
    localparam int PROD_W    = 2 * D_W;            // signed products
    localparam int DOT_W     = PROD_W + 1;         // dot and |ab|^2
    localparam int T_W       = FRAC_BITS + 1;      // t in 0..1
    localparam int OFF_W     = D_W - 1 + T_W;      // |ab| * t + half
    localparam int RES_W     = OFF_W - FRAC_BITS;  // residual magnitude
    localparam int SQ_W      = 2 * RES_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int DIST_W    = 63;
    localparam int IN_W      = 192;
    localparam int OUT_W     = 64;

    localparam logic [T_W-1:0]    T_ONE    = T_W'(1) << FRAC_BITS;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // vectors that travel along the pipeline with each request
    typedef struct packed {
        logic signed [D_W-1:0] apx;
        logic signed [D_W-1:0] apy;
        logic signed [D_W-1:0] abx;
        logic signed [D_W-1:0] aby;
    } t_psd_vec;

endpackage
`default_nettype wire

// ===== rtl/core/psd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psd_front
// Differences, products, then dot(ap,ab) and |ab|^2: three register stages.
// ---------------------------------------------------------------------------
module psd_front import psd_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_vld,
    input  wire logic signed [LNG_W-1:0] i_point_lng,
    input  wire logic signed [LAT_W-1:0] i_point_lat,
    input  wire logic signed [LNG_W-1:0] i_start_lng,
    input  wire logic signed [LAT_W-1:0] i_start_lat,
    input  wire logic signed [LNG_W-1:0] i_end_lng,
    input  wire logic signed [LAT_W-1:0] i_end_lat,
    output logic                         o_vld,
    output t_psd_vec                     o_vec,
    output logic signed [DOT_W-1:0]      o_dot,
    output logic        [DOT_W-1:0]      o_ab2
);

    logic [2:0] r_vld;
    t_psd_vec   r_vec1, r_vec2, r_vec3;
    t_psd_vec   n_vec1;
    logic signed [PROD_W-1:0] r_pxx, r_pyy, r_dx, r_dy;
    logic signed [DOT_W-1:0]  r_dot;
    logic        [DOT_W-1:0]  r_ab2;

    // stage 1: differences
    always_comb begin
        n_vec1.apx = D_W'(i_point_lng) - D_W'(i_start_lng);
        n_vec1.abx = D_W'(i_end_lng)   - D_W'(i_start_lng);
        n_vec1.apy = D_W'(i_point_lat) - D_W'(i_start_lat);
        n_vec1.aby = D_W'(i_end_lat)   - D_W'(i_start_lat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec1 <= n_vec1;
            // stage 2: products
            r_pxx  <= r_vec1.abx * r_vec1.abx;
            r_pyy  <= r_vec1.aby * r_vec1.aby;
            r_dx   <= r_vec1.apx * r_vec1.abx;
            r_dy   <= r_vec1.apy * r_vec1.aby;
            r_vec2 <= r_vec1;
            // stage 3: sums
            r_ab2  <= DOT_W'($unsigned(r_pxx)) + DOT_W'($unsigned(r_pyy));
            r_dot  <= DOT_W'(r_dx) + DOT_W'(r_dy);
            r_vec3 <= r_vec2;
        end
    end

    assign o_vld = r_vld[2];
    assign o_vec = r_vec3;
    assign o_dot = r_dot;
    assign o_ab2 = r_ab2;

endmodule
`default_nettype wire

// ===== rtl/core/psd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psd_div
// Clamp decision, then one restoring-division bit per stage for t.
// ---------------------------------------------------------------------------
module psd_div import psd_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  wire t_psd_vec               i_vec,
    input  wire logic signed [DOT_W-1:0] i_dot,
    input  wire logic        [DOT_W-1:0] i_ab2,
    output logic                        o_vld,
    output t_psd_vec                    o_vec,
    output logic [T_W-1:0]              o_t
);

    logic                 r_vld  [0:FRAC_BITS];
    logic                 r_zero [0:FRAC_BITS];
    logic                 r_full [0:FRAC_BITS];
    logic [DOT_W-1:0]     r_rem  [0:FRAC_BITS];
    logic [DOT_W-1:0]     r_den  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_q    [0:FRAC_BITS];
    t_psd_vec             r_vec  [0:FRAC_BITS];
    logic                 w_pos;

    // decision stage: t = 0 behind start or for a zero-length segment, t = 1 at or beyond end
    assign w_pos = !i_dot[DOT_W-1] && (i_dot != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_ab2 == '0) || !w_pos;
            r_full[0] <= $unsigned(i_dot) >= i_ab2;
            r_rem[0]  <= $unsigned(i_dot);
            r_den[0]  <= i_ab2;
            r_q[0]    <= '0;
            r_vec[0]  <= i_vec;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_bit
        logic [DOT_W:0] w_sh;
        logic           w_ge;

        assign w_sh = {r_rem[k-1], 1'b0};
        assign w_ge = w_sh >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? DOT_W'(w_sh - {1'b0, r_den[k-1]}) : DOT_W'(w_sh);
                r_den[k]  <= r_den[k-1];
                r_q[k]    <= {r_q[k-1][FRAC_BITS-2:0], w_ge};
                r_zero[k] <= r_zero[k-1];
                r_full[k] <= r_full[k-1];
                r_vec[k]  <= r_vec[k-1];
            end
        end
    end

    // clamp select
    always_comb begin
        if (r_zero[FRAC_BITS]) begin
            o_t = '0;
        end else if (r_full[FRAC_BITS]) begin
            o_t = T_ONE;
        end else begin
            o_t = {1'b0, r_q[FRAC_BITS]};
        end
    end

    assign o_vld = r_vld[FRAC_BITS];
    assign o_vec = r_vec[FRAC_BITS];

endmodule
`default_nettype wire

// ===== rtl/core/psd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psd_back
// Rounded offsets, residuals, squares, then saturating sum: four stages.
// ---------------------------------------------------------------------------
module psd_back import psd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire t_psd_vec          i_vec,
    input  wire logic [T_W-1:0]    i_t,
    output logic                   o_vld,
    output logic [DIST_W-1:0]      o_dist_sq,
    output logic                   o_saturated
);

    localparam logic [OFF_W-1:0] HALF = OFF_W'(1) << (FRAC_BITS - 1);

    logic [2:0]                r_vld;
    logic                      r_out_vld;
    logic [OFF_W-1:0]          r_offx, r_offy;
    logic                      r_sx, r_sy;
    logic signed [D_W-1:0]     r_apx, r_apy;
    logic [RES_W-1:0]          r_rx, r_ry;
    logic [SQ_W-1:0]           r_qx, r_qy;
    logic [DIST_W-1:0]         r_dist;
    logic                      r_sat;
    logic [D_W-1:0]            w_mx, w_my;
    logic signed [RES_W:0]     w_ox, w_oy, w_resx, w_resy;
    logic [SUM_W-1:0]          w_sum;

    // stage 1 inputs: |ab| per axis
    assign w_mx = i_vec.abx[D_W-1] ? D_W'(-i_vec.abx) : D_W'(i_vec.abx);
    assign w_my = i_vec.aby[D_W-1] ? D_W'(-i_vec.aby) : D_W'(i_vec.aby);

    // stage 2 inputs: signed rounded offsets and residuals
    always_comb begin
        w_ox   = r_sx ? -$signed({1'b0, r_offx[OFF_W-1:FRAC_BITS]})
                      :  $signed({1'b0, r_offx[OFF_W-1:FRAC_BITS]});
        w_oy   = r_sy ? -$signed({1'b0, r_offy[OFF_W-1:FRAC_BITS]})
                      :  $signed({1'b0, r_offy[OFF_W-1:FRAC_BITS]});
        w_resx = (RES_W+1)'(r_apx) - w_ox;
        w_resy = (RES_W+1)'(r_apy) - w_oy;
    end

    assign w_sum = SUM_W'(r_qx) + SUM_W'(r_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= {r_vld[1:0], i_vld};
            r_out_vld <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1
            r_offx <= OFF_W'(w_mx * i_t) + HALF;
            r_offy <= OFF_W'(w_my * i_t) + HALF;
            r_sx   <= i_vec.abx[D_W-1];
            r_sy   <= i_vec.aby[D_W-1];
            r_apx  <= i_vec.apx;
            r_apy  <= i_vec.apy;
            // stage 2
            r_rx   <= w_resx[RES_W] ? RES_W'(-w_resx) : RES_W'(w_resx);
            r_ry   <= w_resy[RES_W] ? RES_W'(-w_resy) : RES_W'(w_resy);
            // stage 3
            r_qx   <= r_rx * r_rx;
            r_qy   <= r_ry * r_ry;
            // stage 4: saturate above the 63-bit range
            r_sat  <= w_sum[SUM_W-1:DIST_W] != '0;
            r_dist <= (w_sum[SUM_W-1:DIST_W] != '0) ? DIST_MAX : w_sum[DIST_W-1:0];
        end
    end

    assign o_vld       = r_out_vld;
    assign o_dist_sq   = r_dist;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

// ===== rtl/core/point_segment_distance_sq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// point_segment_distance_sq
// Squared distance from a point to a segment, fully pipelined.
// ---------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser
//  s_axis    in   point/start/end lng,lat (189 of 192b)   -
//  m_axis    out  dist_sq (63 of 64b)                     saturated
//
//  One request per cycle while m_axis is not stalled; pipeline stages: 3 front, 17 divide, 4 back.
//  The 16-stage restoring divider for t sets the depth.
//  Reset clears all valid bits; data registers are not reset.
//  A stall on m_axis freezes the whole pipe; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "point_segment_distance_sq_macros.svh"

module point_segment_distance_sq import psd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // point_lng, point_lat, start_lng, start_lat, end_lng, end_lat, zero pad
    input  wire logic [IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // dist_sq, zero pad
    output logic [OUT_W-1:0]      o_m_tdata,
    // saturated
    output logic                  o_m_tuser
);

    logic                    w_en;
    logic                    w_f_vld, w_d_vld, w_b_vld;
    t_psd_vec                w_f_vec, w_d_vec;
    logic signed [DOT_W-1:0] w_dot;
    logic        [DOT_W-1:0] w_ab2;
    logic [T_W-1:0]          w_t;
    logic [DIST_W-1:0]       w_dist;
    logic                    w_sat;

    // whole pipe advances unless a finished result is held
    assign w_en       = !w_b_vld || i_m_tready;
    assign o_s_tready = w_en;

    psd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (i_s_tvalid),
        .i_point_lng (i_s_tdata[31:0]),
        .i_point_lat (i_s_tdata[62:32]),
        .i_start_lng (i_s_tdata[94:63]),
        .i_start_lat (i_s_tdata[125:95]),
        .i_end_lng   (i_s_tdata[157:126]),
        .i_end_lat   (i_s_tdata[188:158]),
        .o_vld       (w_f_vld),
        .o_vec       (w_f_vec),
        .o_dot       (w_dot),
        .o_ab2       (w_ab2)
    );

    psd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_vec   (w_f_vec),
        .i_dot   (w_dot),
        .i_ab2   (w_ab2),
        .o_vld   (w_d_vld),
        .o_vec   (w_d_vec),
        .o_t     (w_t)
    );

    psd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (w_d_vld),
        .i_vec       (w_d_vec),
        .i_t         (w_t),
        .o_vld       (w_b_vld),
        .o_dist_sq   (w_dist),
        .o_saturated (w_sat)
    );

    assign o_m_tvalid = w_b_vld;
    assign o_m_tdata  = {{(OUT_W-DIST_W){1'b0}}, w_dist};
    assign o_m_tuser  = w_sat;

    // checks
    `PSD_ASSERT(a_sat_max, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[DIST_W-1:0] == DIST_MAX))
    `PSD_ASSERT(a_t_range, i_clk, i_rst_n, w_d_vld |-> (w_t <= T_ONE))
    `PSD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid)
    `PSD_ASSERT(a_ready_rule, i_clk, i_rst_n, o_s_tready == (!o_m_tvalid || i_m_tready))

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench : point_segment_distance_sq
// Drives point/segment requests over the input stream and predicts each
// squared distance and saturation flag with an exact wide-integer model.
// Results are checked in order. Directed corners come first, then random
// requests under changing sender and receiver idling.
// ---------------------------------------------------------------------------
module testbench;
    import psd_pkg::*;

    typedef struct {
        logic [LNG_W-1:0] p_lng;
        logic [LAT_W-1:0] p_lat;
        logic [LNG_W-1:0] a_lng;
        logic [LAT_W-1:0] a_lat;
        logic [LNG_W-1:0] b_lng;
        logic [LAT_W-1:0] b_lat;
    } t_query;

    typedef struct {
        logic [DIST_W-1:0] dist_sq;
        logic              saturated;
    } t_dist;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;

    t_dist  dist_queue[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     mismatches = 0;
    int     requests_sent = 0;
    int     results_seen = 0;
    int     saturated_seen = 0;
    int     quiet_cycles = 0;
    localparam int QUIET_LIMIT = 5000;

    point_segment_distance_sq i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // exact predictor: 128-bit signed arithmetic covers every product
    function automatic t_dist predict_dist(t_query q);
        logic signed [127:0] px, py, ax, ay, bx, by;
        logic signed [127:0] apx, apy, abx, aby, dot, ab2, t, ox, oy, r1, r2, sum;
        logic [127:0]        mx, my;
        t_dist               res;
        px = 128'(signed'(q.p_lng));
        py = 128'(signed'(q.p_lat));
        ax = 128'(signed'(q.a_lng));
        ay = 128'(signed'(q.a_lat));
        bx = 128'(signed'(q.b_lng));
        by = 128'(signed'(q.b_lat));
        apx = px - ax;
        apy = py - ay;
        abx = bx - ax;
        aby = by - ay;
        dot = apx * abx + apy * aby;
        ab2 = abx * abx + aby * aby;
        t = 0;
        if (ab2 != 0 && dot > 0) begin
            if (dot >= ab2) t = 128'sd1 <<< FRAC_BITS;
            else t = (dot <<< FRAC_BITS) / ab2;
        end
        // offsets rounded half away from zero
        mx = ((abx < 0 ? -abx : abx) * t + (128'sd1 <<< (FRAC_BITS - 1))) >> FRAC_BITS;
        my = ((aby < 0 ? -aby : aby) * t + (128'sd1 <<< (FRAC_BITS - 1))) >> FRAC_BITS;
        ox = abx < 0 ? -signed'(mx) : signed'(mx);
        oy = aby < 0 ? -signed'(my) : signed'(my);
        r1 = apx - ox;
        r2 = apy - oy;
        sum = r1 * r1 + r2 * r2;
        if (sum > 128'sh7FFF_FFFF_FFFF_FFFF) begin
            res.dist_sq = DIST_MAX;
            res.saturated = 1'b1;
        end else begin
            res.dist_sq = sum[DIST_W-1:0];
            res.saturated = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // one request: random gap, then hold valid until accepted
    task automatic send_query(t_query q);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, q.b_lat, q.b_lng, q.a_lat, q.a_lng, q.p_lat, q.p_lng};
        do begin
            @(negedge i_clk);
            rdy = s_tready;
            @(posedge i_clk);
        end while (!rdy);
        dist_queue.insert(dist_queue.size(), predict_dist(q));
        requests_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (dist_queue.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result check and watchdog; values at the falling edge hold through the next rise
    always @(negedge i_clk) begin
        t_dist want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                if (dist_queue.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
                end else begin
                    want = dist_queue.pop_front();
                    if (m_tdata[DIST_W-1:0] !== want.dist_sq)
                        report_mismatch("dist_sq", 64'(m_tdata[DIST_W-1:0]), 64'(want.dist_sq));
                    if (m_tdata[OUT_W-1:DIST_W] !== '0)
                        report_mismatch("pad", 64'(m_tdata[OUT_W-1:DIST_W]), 64'd0);
                    if (m_tuser !== want.saturated)
                        report_mismatch("saturated", 64'(m_tuser), 64'(want.saturated));
                    if (want.saturated) saturated_seen++;
                end
                results_seen++;
            end else if (s_tvalid && s_tready) begin
                quiet_cycles = 0;
            end else if (s_tvalid || dist_queue.size() != 0) begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("FAIL point_segment_distance_sq");
                    $finish;
                end
            end
        end
    end

    function automatic t_query make_query(longint plng, longint plat, longint alng,
                                          longint alat, longint blng, longint blat);
        t_query q;
        q.p_lng = plng[LNG_W-1:0];
        q.p_lat = plat[LAT_W-1:0];
        q.a_lng = alng[LNG_W-1:0];
        q.a_lat = alat[LAT_W-1:0];
        q.b_lng = blng[LNG_W-1:0];
        q.b_lat = blat[LAT_W-1:0];
        return q;
    endfunction

    function automatic longint rand_lng();
        return longint'($urandom_range(32'd3600000000)) - 64'sd1800000000;
    endfunction

    function automatic longint rand_lat();
        return longint'($urandom_range(32'd1800000000)) - 64'sd900000000;
    endfunction

    function automatic longint jitter(int span);
        return longint'($urandom_range(2 * span)) - longint'(span);
    endfunction

    task automatic test_corners();
        // extremes, zero-length segment, behind start, beyond end, interior
        send_query(make_query(0, 0, 0, 0, 0, 0));
        send_query(make_query(1800000000, 900000000, -1800000000, -900000000,
                              -1800000000, -900000000));
        send_query(make_query(-1800000000, -900000000, 1800000000, 900000000,
                              1800000000, 900000000));
        send_query(make_query(5, 7, 5, 7, 5, 7));
        send_query(make_query(-10, 0, 0, 0, 100, 0));
        send_query(make_query(250, 3, 0, 0, 100, 0));
        send_query(make_query(100, 50, 0, 0, 100, 0));
        send_query(make_query(33, 17, 0, 0, 100, 0));
        send_query(make_query(1, 1, 0, 0, 3, 0));
        send_query(make_query(2, 5, 0, 0, 3, 7));
        send_query(make_query(-7, 9, 1, -1, -3, 2));
        send_query(make_query(0, 900000000, -1800000000, -900000000,
                              1800000000, -900000000));
        send_query(make_query(0, 0, -1800000000, -900000000, 1800000000, 900000000));
        // raw bit patterns past the nominal range, saturating sums
        send_query(make_query(32'h7FFF_FFFF, 31'h3FFF_FFFF, 32'h8000_0000, 31'h4000_0000,
                              32'h8000_0000, 31'h4000_0000));
        send_query(make_query(32'h8000_0000, 31'h4000_0000, 32'h7FFF_FFFF, 31'h3FFF_FFFF,
                              32'h7FFF_FFFF, 31'h3FFF_FFFF));
        send_query(make_query(32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h3FFF_FFFF,
                              32'h8000_0000, 31'h4000_0000));
        send_query(make_query(32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000, 31'h4000_0000,
                              32'h8000_0000, 31'h3FFF_FFFF));
        send_query(make_query(32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000,
                              32'h8000_0000, 31'h4000_0000));
    endtask

    // arbitrary bit patterns in every field
    task automatic test_raw_bits(int count);
        t_query q;
        repeat (count) begin
            q.p_lng = $urandom;
            q.p_lat = LAT_W'($urandom);
            q.a_lng = $urandom;
            q.a_lat = LAT_W'($urandom);
            q.b_lng = $urandom;
            q.b_lat = LAT_W'($urandom);
            send_query(q);
        end
    endtask

    // coordinates inside the nominal degree ranges
    task automatic test_globe(int count);
        repeat (count)
            send_query(make_query(rand_lng(), rand_lat(), rand_lng(), rand_lat(),
                                  rand_lng(), rand_lat()));
    endtask

    // short segments with the point close by: interior t and rounding
    task automatic test_near_segment(int count);
        longint ax, ay;
        int     span;
        repeat (count) begin
            ax = rand_lng();
            ay = rand_lat();
            span = ($urandom_range(3) == 0) ? 1000000 : 200;
            send_query(make_query(ax + jitter(span), ay + jitter(span), ax, ay,
                                  ax + jitter(span), ay + jitter(span)));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 16;
        recv_stall_pct = 74;
        test_corners();
        drain_results();
        test_raw_bits(120);
        test_globe(120);
        test_near_segment(240);

        // hold off until the pipe is empty
        drain_results();
        send_idle_pct = 74;
        recv_stall_pct = 16;
        test_raw_bits(120);
        test_globe(120);
        test_near_segment(240);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_raw_bits(120);
        test_globe(120);
        test_near_segment(240);

        drain_results();
        repeat (40) @(posedge i_clk);
        $display("covered %0d requests: corners, raw bit patterns, globe-wide and near-segment",
                 requests_sent);
        $display("checked %0d results, %0d saturated, %0d mismatches",
                 results_seen, saturated_seen, mismatches);
        if (mismatches == 0 && dist_queue.size() == 0) begin
            $display("PASS point_segment_distance_sq");
        end else begin
            $display("FAIL point_segment_distance_sq");
        end
        $finish;
    end
endmodule
